/* rtl/midi_clock_tempo_averager_defines.svh */
// Assertion macros for the RTL file that checks itself.
`ifndef MIDI_CLOCK_TEMPO_AVERAGER_DEFINES_SVH
`define MIDI_CLOCK_TEMPO_AVERAGER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define MCTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcta assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MCTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcta assertion failed");
`else
`define MCTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MCTA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/mcta_pkg.sv */
package mcta_pkg;

    localparam int QUARTERS_AVERAGED_DEF = 8;
    localparam int RING_DEPTH_DEF        = 192;
    localparam int TICKS_PER_QUARTER     = 24;

    localparam int INTERVAL_W  = 16;
    localparam int TIMESTAMP_W = 32;
    localparam int AVERAGE_W   = 16;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

endpackage

/* rtl/mcta_divide.sv */
module mcta_divide #(
    parameter int QUARTERS_AVERAGED = mcta_pkg::QUARTERS_AVERAGED_DEF,
    parameter int SUM_W             = 24
) (
    input  logic                           clk,
    input  logic                           load,
    input  logic [SUM_W-1:0]               sum,
    output logic [mcta_pkg::AVERAGE_W-1:0] quotient
);

    // Divide by a constant through an exact reciprocal: k = SUM_W + ceil(log2 Q).
    localparam int K      = SUM_W + $clog2(QUARTERS_AVERAGED);
    localparam int PROD_W = SUM_W + K + 1;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << K) + 64'(QUARTERS_AVERAGED) - 64'd1) / 64'(QUARTERS_AVERAGED);
    localparam logic [K:0] RECIP = RECIP_WIDE[K:0];
    localparam int QUOT_W = PROD_W - K;

    logic [PROD_W-1:0]               product;
    logic [QUOT_W-1:0]               quot;
    logic [mcta_pkg::AVERAGE_W-1:0]  quotient_reg;
    logic [mcta_pkg::AVERAGE_W-1:0]  quotient_next;

    assign product = PROD_W'(sum) * PROD_W'(RECIP);
    assign quot    = product[PROD_W-1:K];

    // Saturate at the top of the output range.
    always_comb
    begin
        if (quot > QUOT_W'({mcta_pkg::AVERAGE_W{1'b1}}))
        begin
            quotient_next = {mcta_pkg::AVERAGE_W{1'b1}};
        end
        else
        begin
            quotient_next = quot[mcta_pkg::AVERAGE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quotient_reg <= quotient_next;
        end
    end

    assign quotient = quotient_reg;

endmodule

/* rtl/midi_clock_tempo_averager.sv */
// A tick word passes the s1, s2 and output registers before out_valid rises; a full
// stage ahead (out_stall) can hold it in any of them.
// Throughput: one word per cycle while in_stall is low; a start word yields no result.
// Reset (rst_n, async, active low) clears positions, refill flag, window sum,
// fill value, written marks and all valid flags at once. Ring memory is not cleared:
// entries whose mark is clear read as the fill value, so no clearing pass is needed.
`include "midi_clock_tempo_averager_defines.svh"

module midi_clock_tempo_averager #(
    parameter int QUARTERS_AVERAGED = mcta_pkg::QUARTERS_AVERAGED_DEF,
    parameter int RING_DEPTH        = mcta_pkg::RING_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [mcta_pkg::TIMESTAMP_W-1:0] timestamp_ms,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mcta_pkg::AVERAGE_W-1:0]   average_period_ms,
    output logic                             quarter_mark
);

    localparam int POS_W   = $clog2(RING_DEPTH);
    localparam int SUM_W   = $clog2(RING_DEPTH * 65535 + 1);
    localparam int PHASE_W = $clog2(mcta_pkg::TICKS_PER_QUARTER);
    localparam int IW      = mcta_pkg::INTERVAL_W;
    localparam int TW      = mcta_pkg::TIMESTAMP_W;

    // ------------------------------------------------------------------
    // Handshake: three stages (s1 = update, s2 = divide, out), each moves
    // when the stage after it has room.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic in_accept;
    logic tick_accept;
    logic start_accept;
    logic b_fire;
    logic c_fire;

    assign out_ready    = !out_valid_reg || !out_stall;
    assign s2_ready     = !s2_valid_reg || out_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign in_stall     = !s1_ready;
    assign in_accept    = in_valid && !in_stall;
    assign tick_accept  = in_accept && (operation == mcta_pkg::OP_TICK);
    assign start_accept = in_accept && (operation == mcta_pkg::OP_START);
    assign b_fire       = s1_valid_reg && s2_ready;
    assign c_fire       = s2_valid_reg && out_ready;

    // ------------------------------------------------------------------
    // Accept stage: position tracking, interval, refill decision, ring read.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   write_position_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic               refill_armed_reg;
    logic [TW-1:0]      previous_time_reg;

    logic [TW-1:0]      diff;
    logic [IW-1:0]      interval_a;
    logic               pos_last;
    logic               refill_a;

    assign diff       = timestamp_ms - previous_time_reg;
    // Saturate long gaps, including those across timestamp wrap.
    assign interval_a = (|diff[TW-1:IW]) ? {IW{1'b1}} : diff[IW-1:0];
    assign pos_last   = (write_position_reg == POS_W'(RING_DEPTH - 1));
    assign refill_a   = refill_armed_reg && (write_position_reg == POS_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_position_reg <= '0;
            phase_reg          <= '0;
            refill_armed_reg   <= 1'b0;
            previous_time_reg  <= '0;
        end
        else if (start_accept)
        begin
            // Rewind the ring and arm the refill; keep the previous time.
            write_position_reg <= '0;
            phase_reg          <= '0;
            refill_armed_reg   <= 1'b1;
        end
        else if (tick_accept)
        begin
            write_position_reg <= pos_last ? '0 : write_position_reg + POS_W'(1);
            // Track position modulo ticks per quarter without a divider.
            if (pos_last || (phase_reg == PHASE_W'(mcta_pkg::TICKS_PER_QUARTER - 1)))
            begin
                phase_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_reg + PHASE_W'(1);
            end
            previous_time_reg <= timestamp_ms;
            if (refill_a)
            begin
                refill_armed_reg <= 1'b0;
            end
        end
    end

    // Stage 1 payload and registered ring read.
    logic [POS_W-1:0] s1_pos_reg;
    logic [IW-1:0]    s1_interval_reg;
    logic             s1_refill_reg;
    logic             s1_quarter_reg;
    logic [IW-1:0]    rd_data_reg;
    logic [IW-1:0]    ring_mem [RING_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= tick_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            s1_pos_reg      <= write_position_reg;
            s1_interval_reg <= interval_a;
            s1_refill_reg   <= refill_a;
            s1_quarter_reg  <= (phase_reg == '0);
            rd_data_reg     <= ring_mem[write_position_reg];
        end
    end

    // ------------------------------------------------------------------
    // Update stage: running sum, ring write, written marks, refill.
    // ------------------------------------------------------------------
    logic [RING_DEPTH-1:0] mark_reg;
    logic [IW-1:0]         fill_value_reg;
    logic [SUM_W-1:0]      window_sum_reg;
    logic [POS_W-1:0]      last_wr_addr_reg;
    logic [IW-1:0]         last_wr_data_reg;
    logic                  last_wr_valid_reg;

    logic                  bypass_hit;
    logic [IW-1:0]         old_entry;
    logic [SUM_W-1:0]      sum_next;

    // The ring read can miss a write made on the same edge; forward it.
    assign bypass_hit = last_wr_valid_reg && (last_wr_addr_reg == s1_pos_reg);

    always_comb
    begin
        if (!mark_reg[s1_pos_reg])
        begin
            old_entry = fill_value_reg;
        end
        else if (bypass_hit)
        begin
            old_entry = last_wr_data_reg;
        end
        else
        begin
            old_entry = rd_data_reg;
        end

        if (s1_refill_reg)
        begin
            sum_next = SUM_W'(s1_interval_reg) * SUM_W'(RING_DEPTH);
        end
        else
        begin
            sum_next = window_sum_reg - SUM_W'(old_entry) + SUM_W'(s1_interval_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg          <= '0;
            fill_value_reg    <= '0;
            window_sum_reg    <= '0;
            last_wr_valid_reg <= 1'b0;
        end
        else if (b_fire)
        begin
            window_sum_reg <= sum_next;
            if (s1_refill_reg)
            begin
                // Every entry now reads as the fill value.
                mark_reg       <= '0;
                fill_value_reg <= s1_interval_reg;
            end
            else
            begin
                mark_reg[s1_pos_reg] <= 1'b1;
                last_wr_valid_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && !s1_refill_reg)
        begin
            ring_mem[s1_pos_reg] <= s1_interval_reg;
            last_wr_addr_reg     <= s1_pos_reg;
            last_wr_data_reg     <= s1_interval_reg;
        end
    end

    // Stage 2: hold the new sum for the divider.
    logic [SUM_W-1:0] s2_sum_reg;
    logic             s2_quarter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            s2_sum_reg     <= sum_next;
            s2_quarter_reg <= s1_quarter_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divide stage: reciprocal multiply into the output register.
    // ------------------------------------------------------------------
    logic quarter_mark_reg;

    mcta_divide #(
        .QUARTERS_AVERAGED (QUARTERS_AVERAGED),
        .SUM_W             (SUM_W)
    ) u_divide (
        .clk      (clk),
        .load     (c_fire),
        .sum      (s2_sum_reg),
        .quotient (average_period_ms)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_fire)
        begin
            quarter_mark_reg <= s2_quarter_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign quarter_mark = quarter_mark_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MCTA_ASSERT_NEXT(a_start_rewinds, clk, rst_n, start_accept,
                      write_position_reg == '0 && phase_reg == '0 && refill_armed_reg)
    `MCTA_ASSERT_IMP(a_refill_at_one, clk, rst_n, s1_valid_reg && s1_refill_reg,
                     s1_pos_reg == POS_W'(1))
    `MCTA_ASSERT_IMP(a_phase_aligned, clk, rst_n, write_position_reg == '0, phase_reg == '0)
    `MCTA_ASSERT_IMP(a_stall_when_full, clk, rst_n, in_stall,
                     s1_valid_reg && s2_valid_reg && out_valid_reg)

endmodule

/* verif/tempo_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the tempo averager, keeps its own copy of the ring,
// predicts each tick's result and compares it with what comes out.
module tempo_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             operation,
    input  logic [mcta_pkg::TIMESTAMP_W-1:0] timestamp_ms,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [mcta_pkg::AVERAGE_W-1:0]   average_period_ms,
    input  logic                             quarter_mark,
    output int                               mismatches,
    output int                               pending,
    output int                               results_checked,
    output int                               refills
);

    localparam int RING     = mcta_pkg::RING_DEPTH_DEF;
    localparam int QUARTERS = mcta_pkg::QUARTERS_AVERAGED_DEF;

    typedef struct packed {
        logic [mcta_pkg::AVERAGE_W-1:0] avg;
        logic                           mark;
    } tempo_result_t;

    logic [mcta_pkg::INTERVAL_W-1:0]  interval_ring [RING];
    bit                               marked [RING];
    logic [mcta_pkg::INTERVAL_W-1:0]  fill_value;
    logic [31:0]                      window_sum;
    int unsigned                      write_pos;
    logic [mcta_pkg::TIMESTAMP_W-1:0] prev_time;
    bit                               refill_armed;

    tempo_result_t expected_q [$];
    tempo_result_t oldest;

    initial
    begin
        mismatches      = 0;
        results_checked = 0;
        refills         = 0;
        pending         = 0;
    end

    // Apply one accepted word to the model; a tick queues its expected result.
    task automatic advance_tempo(input mcta_pkg::op_t op,
                                 input logic [mcta_pkg::TIMESTAMP_W-1:0] now);
        logic [31:0]                     diff;
        logic [mcta_pkg::INTERVAL_W-1:0] interval;
        logic [31:0]                     quotient;
        int unsigned                     pos;
        tempo_result_t                   res;
        if (op == mcta_pkg::OP_START)
        begin
            refill_armed = 1'b1;
            write_pos    = 0;
            return;
        end
        pos      = write_pos;
        diff     = now - prev_time;
        interval = (diff > 32'h0000_FFFF) ? 16'hFFFF : diff[15:0];
        if (refill_armed && pos == 1)
        begin
            // Second tick after start: every entry takes this interval.
            for (int i = 0; i < RING; i++)
                marked[i] = 1'b0;
            fill_value   = interval;
            window_sum   = 32'(interval) * RING;
            refill_armed = 1'b0;
            refills++;
        end
        else
        begin
            window_sum = window_sum - (marked[pos] ? interval_ring[pos] : fill_value)
                         + interval;
            interval_ring[pos] = interval;
            marked[pos]        = 1'b1;
        end
        quotient  = window_sum / QUARTERS;
        res.avg   = (quotient > 32'h0000_FFFF) ? 16'hFFFF : quotient[15:0];
        res.mark  = (pos % mcta_pkg::TICKS_PER_QUARTER) == 0;
        expected_q.push_back(res);
        write_pos = (pos + 1) % RING;
        prev_time = now;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING; i++)
            begin
                interval_ring[i] = '0;
                marked[i]        = 1'b0;
            end
            fill_value   = '0;
            window_sum   = '0;
            write_pos    = 0;
            prev_time    = '0;
            refill_armed = 1'b0;
            expected_q.delete();
            pending      = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                advance_tempo(mcta_pkg::op_t'(operation), timestamp_ms);
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, average %0d mark %0d",
                             $time, average_period_ms, quarter_mark);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    results_checked++;
                    if (average_period_ms !== oldest.avg)
                    begin
                        $display("%0t: average_period_ms expected %0d, got %0d",
                                 $time, oldest.avg, average_period_ms);
                        mismatches++;
                    end
                    if (quarter_mark !== oldest.mark)
                    begin
                        $display("%0t: quarter_mark expected %0d, got %0d",
                                 $time, oldest.mark, quarter_mark);
                        mismatches++;
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

/* verif/tb_midi_clock_tempo_averager.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the MIDI clock tempo averager. The checker beside
// the block does all prediction and comparison; this module only feeds words,
// shapes the idle and stall patterns and decides pass or fail.
module tb_midi_clock_tempo_averager;

    // The limit leaves a wide margin over ~1100 words even with both sides
    // idling heavily.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 270;
    localparam int DRAIN_CYCLES = 20;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic                             operation;
    logic [mcta_pkg::TIMESTAMP_W-1:0] timestamp_ms;
    logic                             out_valid;
    logic                             out_stall;
    logic [mcta_pkg::AVERAGE_W-1:0]   average_period_ms;
    logic                             quarter_mark;

    int mismatches;
    int pending;
    int results_checked;
    int refills;

    int          idle_pct;
    int          stall_pct;
    int          cycle_count;
    int          tick_words;
    int          start_words;
    logic [31:0] clock_ms;

    midi_clock_tempo_averager dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .timestamp_ms      (timestamp_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .average_period_ms (average_period_ms),
        .quarter_mark      (quarter_mark)
    );

    tempo_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .timestamp_ms      (timestamp_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .average_period_ms (average_period_ms),
        .quarter_mark      (quarter_mark),
        .mismatches        (mismatches),
        .pending           (pending),
        .results_checked   (results_checked),
        .refills           (refills)
    );

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = mcta_pkg::OP_TICK;
        timestamp_ms = '0;
        out_stall    = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        cycle_count  = 0;
        tick_words   = 0;
        start_words  = 0;
        clock_ms     = '0;
    end

    always #1 clk = ~clk;

    // Hard stop in case the block hangs on either handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure: a fresh coin toss every cycle, held low in reset.
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

    // Offer one word, possibly after some idle cycles, and hold it until taken.
    // Valid stays high on return so back-to-back words leave no bubble.
    task automatic send_word(input mcta_pkg::op_t op, input logic [31:0] stamp);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        timestamp_ms <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == mcta_pkg::OP_START)
            start_words++;
        else
            tick_words++;
        @(negedge clk);
    endtask

    // Advance the running clock by some step and send it as a tick.
    task automatic send_tick_after(input logic [31:0] step);
        clock_ms = clock_ms + step;
        send_word(mcta_pkg::OP_TICK, clock_ms);
    endtask

    initial
    begin
        int          run_len;
        int          base;
        int          pick;
        int          phase_start;
        int          sent;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, no idling on either side.
        // First tick after reset measures from time zero.
        send_word(mcta_pkg::OP_TICK, 32'd0);
        send_word(mcta_pkg::OP_TICK, 32'd100);
        // Huge jump: interval saturates at 65535.
        send_word(mcta_pkg::OP_TICK, 32'hFFFF_FFFF);
        // Timestamp wraps: modulo difference is small.
        send_word(mcta_pkg::OP_TICK, 32'd5);
        send_word(mcta_pkg::OP_TICK, 32'd5);
        // Start leaves the previous time alone; its timestamp does not matter.
        send_word(mcta_pkg::OP_START, 32'hFFFF_FFFF);
        send_word(mcta_pkg::OP_TICK, 32'd25);
        // Refill with a saturated interval drives the average past 65535.
        send_word(mcta_pkg::OP_TICK, 32'd70025);
        send_word(mcta_pkg::OP_TICK, 32'd70055);
        // Back-to-back starts, then a refill at a steady 1000 ms.
        send_word(mcta_pkg::OP_START, 32'h0000_0000);
        send_word(mcta_pkg::OP_START, 32'h8000_0000);
        send_word(mcta_pkg::OP_TICK, 32'd71055);
        send_word(mcta_pkg::OP_TICK, 32'd72055);
        send_word(mcta_pkg::OP_TICK, 32'd73055);
        // Restart before the refill lands, so the arm carries to the next run.
        send_word(mcta_pkg::OP_START, 32'd74000);
        send_word(mcta_pkg::OP_TICK, 32'd74010);
        send_word(mcta_pkg::OP_START, 32'd74020);
        send_word(mcta_pkg::OP_TICK, 32'd74030);
        send_word(mcta_pkg::OP_TICK, 32'd74050);
        send_word(mcta_pkg::OP_TICK, 32'd74070);
        send_word(mcta_pkg::OP_TICK, 32'd74090);
        clock_ms = 32'd74090;

        // Random part: mostly start-then-run sequences at a steady tempo with
        // jitter, some long enough to wrap the ring, sprinkled with jumps,
        // wild timestamps and starts cut into the middle of a run.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            phase_start = tick_words + start_words;
            while (tick_words + start_words - phase_start < PHASE_WORDS)
            begin
                run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(180, 420)
                                                      : $urandom_range(1, 30);
                base    = ($urandom_range(0, 5) == 0) ? $urandom_range(2000, 5000)
                                                      : $urandom_range(5, 600);
                if ($urandom_range(0, 9) < 7)
                    send_word(mcta_pkg::OP_START, $urandom);
                // Trim the run so the phase stays within its word budget.
                sent = tick_words + start_words - phase_start;
                if (run_len > PHASE_WORDS - sent)
                    run_len = PHASE_WORDS - sent;
                repeat (run_len)
                begin
                    pick = $urandom_range(0, 59);
                    if (pick == 0)
                    begin
                        clock_ms = $urandom;
                        send_word(mcta_pkg::OP_TICK, clock_ms);
                    end
                    else if (pick == 1)
                        send_tick_after($urandom);
                    else if (pick == 2)
                        send_tick_after($urandom_range(60000, 70000));
                    else if (pick == 3)
                        send_word(mcta_pkg::OP_START, $urandom);
                    else if (pick == 4)
                        send_tick_after(32'd0);
                    else
                        send_tick_after(base + $urandom_range(0, base / 8));
                end
            end
        end

        // Drop valid and let everything drain.
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d tick and %0d start words over four idle/stall phases;",
                 tick_words, start_words);
        $display("checked %0d results, %0d ring refills, %0d mismatches.",
                 results_checked, refills, mismatches);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mcta_pkg.sv
rtl/mcta_divide.sv
rtl/midi_clock_tempo_averager.sv
verif/tempo_checker.sv
verif/tb_midi_clock_tempo_averager.sv
